[design/csv_field_tokenizer_classifier_macros.svh]
// ----------------------------------------------------------------------------
// csv field tokenizer assertion macros
// shared assertion wrappers for the tokenizer checker
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_CLASSIFIER_MACROS_SVH
`define CSV_FIELD_TOKENIZER_CLASSIFIER_MACROS_SVH

// property checked outside reset
`define CFTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also covers the reset cycles
`define CFTC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/cftc_pkg.sv]
// ----------------------------------------------------------------------------
// cftc_pkg
// shared types, character codes and classifier functions of the tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cftc_pkg;

  // default geometry
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLS_DEF    = 32;
  localparam int FIELD_LIMIT_DEF = 254;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // fixed widths of the result fields
  localparam int ROW_OUT_W  = 6;
  localparam int COL_OUT_W  = 5;
  localparam int LEN_OUT_W  = 8;
  localparam int M_TDATA_W  = 32;

  // character codes
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;

  typedef enum logic [2:0] {
    CL_START   = 3'd0,
    CL_MINUS   = 3'd1,
    CL_INT     = 3'd2,
    CL_FLOAT   = 3'd3,
    CL_STRING  = 3'd4,
    CL_FORMULA = 3'd5
  } class_t;

  typedef enum logic [2:0] {
    FT_EMPTY   = 3'd0,
    FT_STRING  = 3'd1,
    FT_INTEGER = 3'd2,
    FT_FLOAT   = 3'd3,
    FT_FORMULA = 3'd4
  } ftype_t;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  // one queue entry: up to two results caused by one request
  typedef struct packed {
    logic                   has_end;
    logic                   has_char;
    logic [ROW_OUT_W-1:0]   end_row;
    logic [COL_OUT_W-1:0]   end_col;
    ftype_t                 end_type;
    logic [LEN_OUT_W-1:0]   end_len;
    logic                   end_fin;
    logic [ROW_OUT_W-1:0]   chr_row;
    logic [COL_OUT_W-1:0]   chr_col;
    logic [7:0]             chr;
  } entry_t;

  // one result on the output side
  typedef struct packed {
    kind_t                  kind;
    logic [ROW_OUT_W-1:0]   row;
    logic [COL_OUT_W-1:0]   column;
    logic [7:0]             out_char;
    ftype_t                 ftype;
    logic [LEN_OUT_W-1:0]   len;
    logic                   finished;
    logic                   last;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic class_t class_next(input class_t s, input logic [7:0] c);
    class_t n;
    case (s)
      CL_START: begin
        if (c == CH_MINUS) n = CL_MINUS;
        else if (is_digit(c)) n = CL_INT;
        else if (c == CH_EQUAL) n = CL_FORMULA;
        else n = CL_STRING;
      end
      CL_MINUS: n = is_digit(c) ? CL_INT : CL_STRING;
      CL_INT: begin
        if (is_digit(c)) n = CL_INT;
        else if (c == CH_DOT) n = CL_FLOAT;
        else n = CL_STRING;
      end
      CL_FLOAT:   n = is_digit(c) ? CL_FLOAT : CL_STRING;
      CL_FORMULA: n = CL_FORMULA;
      default:    n = CL_STRING;
    endcase
    return n;
  endfunction

  function automatic ftype_t class_type(input class_t s);
    ftype_t t;
    case (s)
      CL_START:   t = FT_EMPTY;
      CL_INT:     t = FT_INTEGER;
      CL_FLOAT:   t = FT_FLOAT;
      CL_FORMULA: t = FT_FORMULA;
      default:    t = FT_STRING;
    endcase
    return t;
  endfunction

endpackage

[design/csv_field_tokenizer_classifier.sv]
// ----------------------------------------------------------------------------
// csv_field_tokenizer_classifier
// streaming csv tokenizer that echoes field bytes and reports field types
// ----------------------------------------------------------------------------
// The block takes csv text one byte per request and never stalls its input
// on its own work: a new byte is accepted every cycle while the internal
// queue has room. Each stored byte is echoed as a character result with its
// row and column; a comma or newline after a non-empty field, a forced split
// at FIELD_LIMIT characters, a newline on the last row or the end-of-input
// flag closes the field with an end result carrying its type (empty, string,
// integer, float or formula) and length. Quote bytes toggle quoting and give
// no result; spaces outside quotes are dropped. From input to output, the
// front registers results into a four-entry queue, the back part registers
// them into the output stage. A byte that forces a split gives two results,
// so it takes the output register twice; the sustained input rate is one
// byte per cycle otherwise, while the result stream is not stalled, bounded
// by the single output register. After the end of input, or a newline on the
// last row, the block drops every further byte. No clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_tokenizer_classifier
  import cftc_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int FIELD_LIMIT = FIELD_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // input byte stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // ch
  input  logic [0:0]           s_axis_tuser,  // end_of_input
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // row, column, out_char, field_type,
                                              // field_length, finished, zero pad
  output logic [0:0]           m_axis_tuser,  // kind
  output logic                 m_axis_tlast   // last
);

  logic   accept;
  logic   push;
  entry_t ent;
  logic   q_full, q_valid, q_pop;
  entry_t q_head;
  res_t   res;

  // conservative: hold off whenever the queue is full
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front: parse state, cell position, field classifier
  cftc_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ch     (s_axis_tdata),
    .eoi    (s_axis_tuser[0]),
    .push   (push),
    .ent    (ent)
  );

  // decoupling queue, one entry per request that yields results
  cftc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push),
    .wr_data   (ent),
    .rd_en     (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_data   (q_head)
  );

  // back: serializes an entry into one or two results
  cftc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_res    (res),
    .out_ready  (m_axis_tready)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {1'b0, res.finished, res.len, res.ftype,
                         res.out_char, res.column, res.row};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

[design/cftc_front.sv]
// ----------------------------------------------------------------------------
// cftc_front
// accepts text bytes, tracks cell position, quoting and field class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cftc_front
  import cftc_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int FIELD_LIMIT = FIELD_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       eoi,
  output logic       push,
  output entry_t     ent
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W = $clog2(FIELD_LIMIT + 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLS - 1);
  localparam logic [CNT_W-1:0] LIMIT    = CNT_W'(FIELD_LIMIT);

  logic [ROW_W-1:0] row, row_next, adv_row;
  logic [COL_W-1:0] col, col_next, adv_col;
  logic             quotes, quotes_next;
  class_t           cls, cls_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             done, done_next;
  logic             split;

  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      col    <= '0;
      quotes <= 1'b0;
      cls    <= CL_START;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      row    <= row_next;
      col    <= col_next;
      quotes <= quotes_next;
      cls    <= cls_next;
      cnt    <= cnt_next;
      done   <= done_next;
    end
  end

  // next cell; stays put on the last cell
  always_comb begin
    adv_row = row;
    adv_col = col;
    if (col != LAST_COL) begin
      adv_col = col + 1'b1;
    end else if (row != LAST_ROW) begin
      adv_row = row + 1'b1;
      adv_col = '0;
    end
  end

  assign split = (cnt >= LIMIT);

  always_comb begin
    row_next    = row;
    col_next    = col;
    quotes_next = quotes;
    cls_next    = cls;
    cnt_next    = cnt;
    done_next   = done;
    ent          = '0;
    ent.end_row  = ROW_OUT_W'(row);
    ent.end_col  = COL_OUT_W'(col);
    ent.end_type = class_type(cls);
    ent.end_len  = LEN_OUT_W'(cnt);
    ent.chr      = ch;
    ent.chr_row  = ROW_OUT_W'(row);
    ent.chr_col  = COL_OUT_W'(col);
    if (accept && !done) begin
      if (eoi) begin
        ent.has_end = 1'b1;
        ent.end_fin = 1'b1;
        cls_next    = CL_START;
        cnt_next    = '0;
        done_next   = 1'b1;
      end else if (ch == CH_LF) begin
        cls_next = CL_START;
        cnt_next = '0;
        if (row != LAST_ROW) begin
          ent.has_end = (cnt != '0);
          quotes_next = 1'b0;
          row_next    = row + 1'b1;
          col_next    = '0;
        end else begin
          ent.has_end = 1'b1;
          ent.end_fin = 1'b1;
          done_next   = 1'b1;
        end
      end else if (ch == CH_QUOTE) begin
        quotes_next = !quotes;
      end else if ((ch != CH_COMMA && ch != CH_SPACE) || quotes) begin
        ent.has_char = 1'b1;
        if (split) begin
          // full field: close it and store the byte into the next cell
          ent.has_end = 1'b1;
          row_next    = adv_row;
          col_next    = adv_col;
          ent.chr_row = ROW_OUT_W'(adv_row);
          ent.chr_col = COL_OUT_W'(adv_col);
          cls_next    = class_next(CL_START, ch);
          cnt_next    = CNT_W'(1);
        end else begin
          cls_next = class_next(cls, ch);
          cnt_next = cnt + 1'b1;
        end
      end else if (ch == CH_COMMA) begin
        ent.has_end = (cnt != '0);
        row_next    = adv_row;
        col_next    = adv_col;
        cls_next    = CL_START;
        cnt_next    = '0;
      end
    end
    push = ent.has_end || ent.has_char;
  end

endmodule

[design/cftc_fifo.sv]
// ----------------------------------------------------------------------------
// cftc_fifo
// short queue of result entries between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cftc_fifo
  import cftc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  input  logic   rd_en,
  output logic   full,
  output logic   not_empty,
  output entry_t rd_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/cftc_back.sv]
// ----------------------------------------------------------------------------
// cftc_back
// splits queue entries into results and holds them in the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cftc_back
  import cftc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   head_valid,
  input  entry_t head,
  output logic   pop,
  output logic   out_valid,
  output res_t   out_res,
  input  logic   out_ready
);

  logic out_vld;
  logic phase, phase_next;
  logic load, take_end;
  res_t res_next;

  assign load      = !out_vld || out_ready;
  assign out_valid = out_vld;
  // end part goes first while the entry still has it pending
  assign take_end  = head.has_end && !phase;

  always_comb begin
    res_next          = '0;
    phase_next        = phase;
    pop               = 1'b0;
    if (take_end) begin
      res_next.kind     = KIND_END;
      res_next.row      = head.end_row;
      res_next.column   = head.end_col;
      res_next.ftype    = head.end_type;
      res_next.len      = head.end_len;
      res_next.finished = head.end_fin;
      res_next.last     = !head.has_char;
    end else begin
      res_next.kind     = KIND_CHAR;
      res_next.row      = head.chr_row;
      res_next.column   = head.chr_col;
      res_next.out_char = head.chr;
      res_next.ftype    = FT_EMPTY;
      res_next.last     = 1'b1;
    end
    if (load && head_valid) begin
      if (take_end && head.has_char) begin
        phase_next = 1'b1;
      end else begin
        phase_next = 1'b0;
        pop        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      phase   <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_vld <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_res <= res_next;
    end
  end

endmodule

[design/cftc_checker.sv]
// ----------------------------------------------------------------------------
// cftc_checker
// port-level checks of the tokenizer result stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "csv_field_tokenizer_classifier_macros.svh"

module cftc_checker
  import cftc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]           m_axis_tuser,
  input logic                 m_axis_tlast
);

  logic        res_chr;
  logic        res_split;
  logic [11:0] res_info;
  logic        res_fin;
  logic [2:0]  res_type;

  // character result offered
  assign res_chr   = m_axis_tvalid && !m_axis_tuser[0];
  // end result with a character still to come from the same request
  assign res_split = m_axis_tvalid && m_axis_tuser[0] && !m_axis_tlast;
  // type, length and finished mark
  assign res_info  = m_axis_tdata[30:19];
  assign res_fin   = m_axis_tdata[30];
  assign res_type  = m_axis_tdata[21:19];

  // no result right after reset
  `CFTC_ASSERT_RST(a_rst_idle, rst |=> !m_axis_tvalid, "result valid after reset")

  // a stalled result stays offered
  `CFTC_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

  // character results are last and carry no type, length or finished mark
  `CFTC_ASSERT(a_char_res, res_chr |-> m_axis_tlast && (res_info == '0), "bad character result")

  // an end result followed by a character in the same request never finishes and is never of empty type
  `CFTC_ASSERT(a_split_end, res_split |-> !res_fin && (res_type != FT_EMPTY), "bad split end")

endmodule

bind csv_field_tokenizer_classifier cftc_checker u_cftc_checker (.*);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench for csv_field_tokenizer_classifier
// Drives one csv document through the tokenizer: directed fields for the type
// classifier, quoting and extreme bytes, a field long enough to force a split,
// random rows with noise, the last row out to its last column, and the end of
// parsing followed by bytes that must be dropped. A predictor works out every
// echoed byte and field end; each result is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cftc_pkg::*;

  // request counts at which the idle pattern changes
  localparam int PHASE_ONE_END  = 320;
  localparam int PHASE_TWO_END  = 640;
  // random rows stop at whichever comes first
  localparam int RANDOM_STOP    = 820;
  localparam int ROW_STOP       = 56;
  // noise newlines are suppressed from this row on
  localparam int QUIET_ROW      = 48;
  localparam int DRAIN_CYCLES   = 20;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;   // ch
  logic [0:0]           s_axis_tuser = '0;   // end_of_input
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // row, column, out_char, field_type,
                                             // field_length, finished, zero pad
  logic [0:0]           m_axis_tuser;        // kind
  logic                 m_axis_tlast;        // last

  csv_field_tokenizer_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tokenizer state as predicted
  logic [ROW_OUT_W-1:0] cur_row = '0;
  logic [COL_OUT_W-1:0] cur_col = '0;
  logic                 quoted = 1'b0;
  class_t               cls = CL_START;
  logic [7:0]           char_count = '0;
  logic                 parse_done = 1'b0;

  res_t       pending_results[$];
  logic [7:0] text_buf[$];
  string      plain_chars = "abcdefghijklmnopqrstuvwxyzQXZ0123456789+-*/.=()_";

  int sent_count      = 0;
  int results_checked = 0;
  int split_count     = 0;
  int error_count     = 0;

  // ---------------------------------------------------------------- predictor

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic class_t next_class(input class_t s, input logic [7:0] c);
    if (s == CL_FORMULA) return CL_FORMULA;
    if (s == CL_START) begin
      if (c == CH_MINUS) return CL_MINUS;
      if (c == CH_EQUAL) return CL_FORMULA;
      return digit_byte(c) ? CL_INT : CL_STRING;
    end
    if (s == CL_MINUS || s == CL_INT || s == CL_FLOAT) begin
      if (digit_byte(c)) return (s == CL_FLOAT) ? CL_FLOAT : CL_INT;
      if (s == CL_INT && c == CH_DOT) return CL_FLOAT;
    end
    return CL_STRING;
  endfunction

  function automatic ftype_t type_of(input class_t s);
    case (s)
      CL_START:   return FT_EMPTY;
      CL_INT:     return FT_INTEGER;
      CL_FLOAT:   return FT_FLOAT;
      CL_FORMULA: return FT_FORMULA;
      default:    return FT_STRING;
    endcase
  endfunction

  function automatic res_t field_end(input logic fin);
    res_t r;
    r = '0;
    r.kind     = KIND_END;
    r.row      = cur_row;
    r.column   = cur_col;
    r.ftype    = type_of(cls);
    r.len      = char_count;
    r.finished = fin;
    return r;
  endfunction

  function automatic res_t stored_char(input logic [7:0] c);
    res_t r;
    r = '0;
    r.kind     = KIND_CHAR;
    r.row      = cur_row;
    r.column   = cur_col;
    r.out_char = c;
    return r;
  endfunction

  function automatic void clear_field();
    char_count = '0;
    cls = CL_START;
  endfunction

  // columns wrap to the next row; the last cell of the last row stays put
  function automatic void next_cell();
    if (int'(cur_col) + 1 < MAX_COLS_DEF) begin
      cur_col++;
    end else if (int'(cur_row) + 1 < MAX_ROWS_DEF) begin
      cur_row++;
      cur_col = '0;
    end
  endfunction

  // works out the results of one accepted request and queues them
  function automatic void tokenize_byte(input logic [7:0] c, input logic eoi);
    res_t step_res[2];
    int   n;
    n = 0;
    if (parse_done) return;
    if (eoi) begin
      step_res[0] = field_end(1'b1);
      n = 1;
      clear_field();
      parse_done = 1'b1;
    end else if (c == CH_LF) begin
      if (int'(cur_row) + 1 < MAX_ROWS_DEF) begin
        if (char_count != 0) begin
          step_res[0] = field_end(1'b0);
          n = 1;
        end
        clear_field();
        quoted = 1'b0;
        cur_row++;
        cur_col = '0;
      end else begin
        // newline on the last row always closes and ends parsing
        step_res[0] = field_end(1'b1);
        n = 1;
        clear_field();
        parse_done = 1'b1;
      end
    end else if (c == CH_QUOTE) begin
      quoted = !quoted;
    end else if ((c != CH_COMMA && c != CH_SPACE) || quoted) begin
      if (char_count >= FIELD_LIMIT_DEF) begin
        // forced split: close the full field, echo into the next cell
        step_res[0] = field_end(1'b0);
        n = 1;
        next_cell();
        clear_field();
        split_count++;
      end
      step_res[n] = stored_char(c);
      n++;
      cls = next_class(cls, c);
      char_count++;
    end else if (c == CH_COMMA) begin
      if (char_count != 0) begin
        step_res[0] = field_end(1'b0);
        n = 1;
      end
      next_cell();
      clear_field();
    end
    if (n > 0) step_res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(step_res[i]);
  endfunction

  // ------------------------------------------------------------------ traffic

  function automatic int sender_idle_pct();
    if (sent_count < PHASE_ONE_END) return 34;
    if (sent_count < PHASE_TWO_END) return 86;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (sent_count < PHASE_ONE_END) return 86;
    if (sent_count < PHASE_TWO_END) return 34;
    return 0;
  endfunction

  // one request; tready is sampled at the falling edge so the accept is
  // known before the rising edge that takes it
  task automatic send_byte(input logic [7:0] c, input logic eoi);
    bit accepted;
    if ($urandom_range(99) < sender_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct());
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= eoi;
    do begin
      @(negedge clk);
      accepted = s_axis_tready;
      @(posedge clk);
    end while (!accepted);
    tokenize_byte(c, eoi);
    sent_count++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    text_buf.push_back(b);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  task automatic flush_text();
    logic [7:0] b;
    while (text_buf.size() != 0) begin
      b = text_buf.pop_front();
      send_byte(b, 1'b0);
    end
  endtask

  function automatic logic [7:0] plain_char();
    return plain_chars[$urandom_range(plain_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // one random cell: mostly well formed, noise only when allowed
  function automatic void add_cell(input bit allow_noise);
    int         kind_sel;
    logic [7:0] b;
    kind_sel = $urandom_range(allow_noise ? 7 : 5);
    if ($urandom_range(7) == 0) add_byte(CH_SPACE);
    case (kind_sel)
      0: begin
        if ($urandom_range(2) == 0) add_byte(CH_MINUS);
        repeat ($urandom_range(1, 4)) add_byte(any_digit());
      end
      1: begin
        if ($urandom_range(2) == 0) add_byte(CH_MINUS);
        repeat ($urandom_range(1, 3)) add_byte(any_digit());
        add_byte(CH_DOT);
        repeat ($urandom_range(0, 3)) add_byte(any_digit());
      end
      2: begin
        add_byte(CH_EQUAL);
        repeat ($urandom_range(0, 4)) add_byte(plain_char());
      end
      3: repeat ($urandom_range(1, 5)) add_byte(plain_char());
      4: begin
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
          do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_LF);
          add_byte(b);
        end
        add_byte(CH_QUOTE);
      end
      5: ;
      default: repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(255));
        if (b == CH_LF && cur_row >= QUIET_ROW) b = CH_SPACE;
        add_byte(b);
      end
    endcase
    if ($urandom_range(7) == 0) add_byte(CH_SPACE);
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_result();
    res_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      $display("%0t: result with no request pending, expected none, actual tdata %h kind %0d",
               $time, m_axis_tdata, m_axis_tuser);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("kind",         int'(want.kind),     int'(m_axis_tuser[0]));
      check_field("row",          int'(want.row),      int'(m_axis_tdata[5:0]));
      check_field("column",       int'(want.column),   int'(m_axis_tdata[10:6]));
      check_field("out_char",     int'(want.out_char), int'(m_axis_tdata[18:11]));
      check_field("field_type",   int'(want.ftype),    int'(m_axis_tdata[21:19]));
      check_field("field_length", int'(want.len),      int'(m_axis_tdata[29:22]));
      check_field("finished",     int'(want.finished), int'(m_axis_tdata[30]));
      check_field("pad",          0,                   int'(m_axis_tdata[31]));
      check_field("last",         int'(want.last),     int'(m_axis_tlast));
    end
  endtask

  initial begin
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct());
      @(negedge clk);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
  end

  // -------------------------------------------------------------------- tests

  // classifier paths: float, lone minus, formula, int to string,
  // float to string, empty fields
  task automatic test_classifier();
    add_text("-1.5,-,=1,9a,1.2.,,");
    flush_text();
  endtask

  // spaces outside quotes dropped, comma and space inside quotes stored,
  // bytes 0 and 255 stored, newline inside quotes closes the field,
  // newline on an empty field gives nothing
  task automatic test_quotes_and_extremes();
    add_text(" \"a, \"b");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text(" ,\"c\n\n");
    flush_text();
  endtask

  // one field past the limit forces a split into the next cell
  task automatic test_long_field();
    bit         quoted_run;
    logic [7:0] b;
    quoted_run = 1'($urandom_range(1));
    if (quoted_run) add_byte(CH_QUOTE);
    repeat (FIELD_LIMIT_DEF + $urandom_range(1, 4)) begin
      if (quoted_run) begin
        do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_LF);
      end else begin
        b = any_digit();
      end
      add_byte(b);
    end
    if (quoted_run) add_byte(CH_QUOTE);
    add_byte(CH_COMMA);
    flush_text();
  endtask

  // rows of random cells; now and then a row wide enough to wrap columns
  task automatic test_random_rows();
    int cells;
    while (sent_count < RANDOM_STOP && cur_row < ROW_STOP) begin
      if ($urandom_range(9) == 0) cells = $urandom_range(MAX_COLS_DEF + 1, MAX_COLS_DEF + 4);
      else cells = $urandom_range(1, 4);
      for (int i = 0; i < cells; i++) begin
        if (i != 0) add_byte(CH_COMMA);
        add_cell(1'b1);
      end
      if ($urandom_range(5) == 0) add_byte(CH_COMMA);
      add_byte(CH_LF);
      flush_text();
    end
  endtask

  // reach the last row, walk it to the last column and keep going there
  task automatic test_last_row();
    while (cur_row < MAX_ROWS_DEF - 1) begin
      if ($urandom_range(1)) add_cell(1'b0);
      add_byte(CH_LF);
      flush_text();
    end
    while (cur_col < MAX_COLS_DEF - 1) begin
      if ($urandom_range(3) == 0) add_cell(1'b0);
      add_byte(CH_COMMA);
      flush_text();
    end
    repeat (3) begin
      add_cell(1'b0);
      add_byte(CH_COMMA);
      flush_text();
    end
  endtask

  // end parsing by last-row newline or end of input, then send bytes that
  // must be dropped
  task automatic test_finish();
    logic [7:0] junk;
    if ($urandom_range(1)) add_cell(1'b0);
    flush_text();
    junk = 8'($urandom_range(255));
    if ($urandom_range(1)) send_byte(CH_LF, 1'b0);
    else send_byte(junk, 1'b1);
    repeat (4) send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(junk, 1'b1);
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_classifier();
    test_quotes_and_extremes();
    test_long_field();
    test_random_rows();
    test_last_row();
    test_finish();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests and %0d results, %0d forced splits",
             sent_count, results_checked, split_count);
    $display("document ended at row %0d column %0d, parse ended %0d",
             cur_row, cur_col, parse_done);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/cftc_pkg.sv
design/cftc_front.sv
design/cftc_fifo.sv
design/cftc_back.sv
design/csv_field_tokenizer_classifier.sv
design/cftc_checker.sv
verif/testbench.sv
